### design/lfu_cache_table_unit_defines.svh
// assertion macros for the lfu cache table rtl
// used by lfu_scan and lfu_cache_table_unit, expects i_clk and i_rst_n in scope
`ifndef LFU_CACHE_TABLE_UNIT_DEFINES_SVH
`define LFU_CACHE_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define LFU_ASSERT(lbl, prop, msg)

`define LFU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### design/lfu_pkg.sv
// shared types and constants for the lfu cache table
// no dependencies
package lfu_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [CFG_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] READ_MISS = 32'hFFFF_FFFF;

    typedef struct packed {
        logic match;
        logic free;
        logic victim;
    } t_scan_flags;

endpackage

### design/lfu_cache_table_unit.sv
// lfu cache table, top level: control sequencer, entry memory and scan unit
// a get miss or an unstored put sweeps the entry memory once (match scan); a get hit or
// a stored put sweeps its single read port twice (match scan, then rank update and write-back)
// o_in_stall stays high until an item is finished, so a new item is not taken before then
// reset: synchronous, then a clearing pass over every slot with o_in_stall high
// depends on lfu_pkg, lfu_mem, lfu_scan and lfu_cache_table_unit_defines.svh
`include "lfu_cache_table_unit_defines.svh"

module lfu_cache_table_unit
    import lfu_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_func,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic signed [DATA_W-1:0] i_data_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_read_value
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW  = $clog2(CAPACITY + 1);
    localparam int CMW = (OW > CFG_W) ? OW : CFG_W;
    localparam int EW  = 1 + KEY_W + DATA_W + COUNT_WIDTH + IW;
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPD,
        ST_OUT
    } t_state;

    t_state                 r_state;
    logic [IW-1:0]          r_clr_idx;
    logic [CFG_W-1:0]       r_cap;
    logic [OW-1:0]          r_occ;
    logic                   r_issuing;
    logic [IW-1:0]          r_rd_idx;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_addr;
    logic                   r_func;
    logic [KEY_W-1:0]       r_key;
    logic [DATA_W-1:0]      r_data;
    logic [IW-1:0]          r_tgt;
    logic [IW-1:0]          r_thr;
    logic                   r_all;
    logic [DATA_W-1:0]      r_new_data;
    logic [COUNT_WIDTH-1:0] r_new_count;
    logic                   r_res_hit;
    logic [DATA_W-1:0]      r_res_data;
    logic                   r_o_valid;
    logic                   r_o_hit;
    logic [DATA_W-1:0]      r_o_data;

    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [EW-1:0]          mem_rdata;

    logic                   rd_valid;
    logic [KEY_W-1:0]       rd_key;
    logic [DATA_W-1:0]      rd_data;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [IW-1:0]          rd_rank;

    t_scan_flags            sc_flags;
    logic [IW-1:0]          sc_match_slot;
    logic [IW-1:0]          sc_match_rank;
    logic [DATA_W-1:0]      sc_match_data;
    logic [COUNT_WIDTH-1:0] sc_match_count;
    logic [IW-1:0]          sc_free_slot;
    logic [IW-1:0]          sc_vict_slot;
    logic [IW-1:0]          sc_vict_rank;
    logic [COUNT_WIDTH-1:0] inc_count;

    logic                   accept;
    logic                   rd_last;
    logic [CMW-1:0]         cap_ext;
    logic [CMW-1:0]         cap_lim;
    logic [CMW-1:0]         occ_ext;

    assign rd_rank  = mem_rdata[IW-1:0];
    assign rd_count = mem_rdata[IW +: COUNT_WIDTH];
    assign rd_data  = mem_rdata[IW + COUNT_WIDTH +: DATA_W];
    assign rd_key   = mem_rdata[IW + COUNT_WIDTH + DATA_W +: KEY_W];
    assign rd_valid = mem_rdata[EW-1];

    assign accept  = (r_state == ST_IDLE) && i_in_valid;
    assign rd_last = r_rd_vld && (r_rd_addr == LAST);

    assign cap_ext = CMW'(r_cap);
    assign cap_lim = (cap_ext > CMW'(CAPACITY)) ? CMW'(CAPACITY) : cap_ext;
    assign occ_ext = CMW'(r_occ);

    assign inc_count = (sc_match_count == '1) ? sc_match_count
                                              : COUNT_WIDTH'(sc_match_count + 1'b1);

    lfu_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (r_issuing),
        .i_raddr (r_rd_idx),
        .o_rdata (mem_rdata)
    );

    lfu_scan #(
        .IW (IW),
        .CW (COUNT_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_en          ((r_state == ST_SCAN) && r_rd_vld),
        .i_idx         (r_rd_addr),
        .i_key         (r_key),
        .i_ent_valid   (rd_valid),
        .i_ent_key     (rd_key),
        .i_ent_data    (rd_data),
        .i_ent_count   (rd_count),
        .i_ent_rank    (rd_rank),
        .o_flags       (sc_flags),
        .o_match_slot  (sc_match_slot),
        .o_match_rank  (sc_match_rank),
        .o_match_data  (sc_match_data),
        .o_match_count (sc_match_count),
        .o_free_slot   (sc_free_slot),
        .o_vict_slot   (sc_vict_slot),
        .o_vict_rank   (sc_vict_rank)
    );

    // write-back: target slot gets the new entry, others age where needed; clear zeroes all
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_addr;
        mem_wdata = mem_rdata;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else if ((r_state == ST_UPD) && r_rd_vld) begin
            mem_we = 1'b1;
            if (r_rd_addr == r_tgt) begin
                mem_wdata = {1'b1, r_key, r_new_data, r_new_count, {IW{1'b0}}};
            end else if (rd_valid && (r_all || (rd_rank < r_thr))) begin
                mem_wdata = {rd_valid, rd_key, rd_data, rd_count, IW'(rd_rank + 1'b1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_cap     <= CAP_RESET;
            r_occ     <= '0;
            r_issuing <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_rd_vld  <= r_issuing;
            r_rd_addr <= r_rd_idx;
            if (r_issuing) begin
                if (r_rd_idx == LAST) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_rd_idx <= IW'(r_rd_idx + 1'b1);
                end
            end
            if (r_o_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= IW'(r_clr_idx + 1'b1);
                    if (r_clr_idx == LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_func    <= i_func;
                        r_key     <= i_key;
                        r_data    <= i_data_value;
                        r_issuing <= 1'b1;
                        r_rd_idx  <= '0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (rd_last) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_func == FUNC_GET) begin
                        r_res_hit   <= sc_flags.match;
                        r_res_data  <= sc_flags.match ? sc_match_data : READ_MISS;
                        r_all       <= 1'b0;
                        r_tgt       <= sc_match_slot;
                        r_thr       <= sc_match_rank;
                        r_new_data  <= sc_match_data;
                        r_new_count <= inc_count;
                        if (sc_flags.match) begin
                            r_issuing <= 1'b1;
                            r_rd_idx  <= '0;
                            r_state   <= ST_UPD;
                        end else begin
                            r_state   <= ST_OUT;
                        end
                    end else if ((cap_lim != '0) && sc_flags.match) begin
                        r_all       <= 1'b0;
                        r_tgt       <= sc_match_slot;
                        r_thr       <= sc_match_rank;
                        r_new_data  <= r_data;
                        r_new_count <= inc_count;
                        r_issuing   <= 1'b1;
                        r_rd_idx    <= '0;
                        r_state     <= ST_UPD;
                    end else if ((cap_lim != '0) && (occ_ext < cap_lim) && sc_flags.free) begin
                        r_all       <= 1'b1;
                        r_tgt       <= sc_free_slot;
                        r_new_data  <= r_data;
                        r_new_count <= COUNT_WIDTH'(1);
                        r_occ       <= OW'(r_occ + 1'b1);
                        r_issuing   <= 1'b1;
                        r_rd_idx    <= '0;
                        r_state     <= ST_UPD;
                    end else if ((cap_lim != '0) && sc_flags.victim) begin
                        r_all       <= 1'b0;
                        r_tgt       <= sc_vict_slot;
                        r_thr       <= sc_vict_rank;
                        r_new_data  <= r_data;
                        r_new_count <= COUNT_WIDTH'(1);
                        r_issuing   <= 1'b1;
                        r_rd_idx    <= '0;
                        r_state     <= ST_UPD;
                    end else begin
                        r_state     <= ST_IDLE;
                    end
                end
                ST_UPD: begin
                    if (rd_last) begin
                        r_state <= (r_func == FUNC_GET) ? ST_OUT : ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_hit   <= r_res_hit;
                        r_o_data  <= r_res_data;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_hit        = r_o_hit;
    assign o_read_value = r_o_data;

    `LFU_ASSERT(a_occ_bound, r_occ <= OW'(CAPACITY), "occupancy above capacity")
    `LFU_ASSERT(a_no_write_in_scan, (r_state == ST_SCAN) |-> !mem_we,
                "entry memory written during match scan")
    `LFU_ASSERT(a_decide_drained, (r_state == ST_DECIDE) |-> (!r_rd_vld && !r_issuing),
                "read sweep still running at decision")
    `LFU_ASSERT(a_result_from_out, $rose(r_o_valid) |-> ($past(r_state) == ST_OUT),
                "result loaded outside output state")
    `LFU_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_state == ST_CLEAR && !r_o_valid),
                       "reset did not start clearing pass")

endmodule

### design/lfu_mem.sv
// single write port, single read port entry memory with registered read data
// no dependencies
module lfu_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/lfu_scan.sv
// scan accumulator: key match, first free slot and lfu victim with lru tiebreak
// depends on lfu_pkg and lfu_cache_table_unit_defines.svh
`include "lfu_cache_table_unit_defines.svh"

module lfu_scan
    import lfu_pkg::*;
#(
    parameter int IW = 4,
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_en,
    input  logic [IW-1:0]     i_idx,
    input  logic [KEY_W-1:0]  i_key,
    input  logic              i_ent_valid,
    input  logic [KEY_W-1:0]  i_ent_key,
    input  logic [DATA_W-1:0] i_ent_data,
    input  logic [CW-1:0]     i_ent_count,
    input  logic [IW-1:0]     i_ent_rank,
    output t_scan_flags       o_flags,
    output logic [IW-1:0]     o_match_slot,
    output logic [IW-1:0]     o_match_rank,
    output logic [DATA_W-1:0] o_match_data,
    output logic [CW-1:0]     o_match_count,
    output logic [IW-1:0]     o_free_slot,
    output logic [IW-1:0]     o_vict_slot,
    output logic [IW-1:0]     o_vict_rank
);

    t_scan_flags       r_flags;
    logic [IW-1:0]     r_match_slot;
    logic [IW-1:0]     r_match_rank;
    logic [DATA_W-1:0] r_match_data;
    logic [CW-1:0]     r_match_count;
    logic [IW-1:0]     r_free_slot;
    logic [IW-1:0]     r_vict_slot;
    logic [IW-1:0]     r_vict_rank;
    logic [CW-1:0]     r_vict_count;
    logic              is_match;
    logic              is_free;
    logic              is_victim;

    assign is_match  = i_ent_valid && (i_ent_key == i_key) && !r_flags.match;
    assign is_free   = !i_ent_valid && !r_flags.free;
    assign is_victim = i_ent_valid && (!r_flags.victim || (i_ent_count < r_vict_count) ||
                       ((i_ent_count == r_vict_count) && (i_ent_rank > r_vict_rank)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_en) begin
            r_flags <= {r_flags.match | is_match, r_flags.free | is_free,
                        r_flags.victim | is_victim};
            if (is_match) begin
                r_match_slot  <= i_idx;
                r_match_rank  <= i_ent_rank;
                r_match_data  <= i_ent_data;
                r_match_count <= i_ent_count;
            end
            if (is_free) begin
                r_free_slot  <= i_idx;
            end
            if (is_victim) begin
                r_vict_slot    <= i_idx;
                r_vict_rank    <= i_ent_rank;
                r_vict_count   <= i_ent_count;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_match_slot  = r_match_slot;
    assign o_match_rank  = r_match_rank;
    assign o_match_data  = r_match_data;
    assign o_match_count = r_match_count;
    assign o_free_slot   = r_free_slot;
    assign o_vict_slot   = r_vict_slot;
    assign o_vict_rank   = r_vict_rank;

    `LFU_ASSERT(a_start_excl_en, !(i_start && i_en), "scan start during data return")
    `LFU_ASSERT(a_match_implies_victim, r_flags.match |-> r_flags.victim,
                "match found without any valid entry seen")

endmodule

### test/lfu_cache_table_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for lfu_cache_table_unit: directed and random get/put traffic
// is predicted by an in-bench lfu model with recency tie-break and checked per result
// depends on lfu_pkg and the lfu_cache_table_unit rtl
module lfu_cache_table_unit_test;
    import lfu_pkg::*;

    localparam int          SLOTS         = 16;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 400;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } t_read_result;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]         i_cfg_wdata  = CAP_RESET;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic                     i_func       = FUNC_GET;
    logic signed [KEY_W-1:0]  i_key        = '0;
    logic signed [DATA_W-1:0] i_data_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic                     o_hit;
    logic signed [DATA_W-1:0] o_read_value;

    // model state
    logic              slot_used  [SLOTS];
    logic [KEY_W-1:0]  slot_key   [SLOTS];
    logic [DATA_W-1:0] slot_data  [SLOTS];
    logic [15:0]       slot_count [SLOTS];
    int                slot_age   [SLOTS];
    int                fill_level;
    logic [CFG_W-1:0]  cap_setting;

    t_read_result pending_reads [$];

    int feed_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int get_total     = 0;
    int hit_total     = 0;
    int put_total     = 0;
    int evict_total   = 0;
    int read_total    = 0;

    lfu_cache_table_unit #(
        .CAPACITY    (SLOTS),
        .COUNT_WIDTH (16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_data_value (i_data_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("error at %0t: %s", $time, what);
        end
    endfunction

    function automatic void clear_model();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_data[i]  = '0;
            slot_count[i] = '0;
            slot_age[i]   = 0;
        end
        fill_level  = 0;
        cap_setting = CAP_RESET;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void promote_slot(input int s);
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
        end
        slot_age[s] = 0;
        if (slot_count[s] != COUNT_MAX) slot_count[s]++;
    endfunction

    // lowest count goes, oldest among equals
    function automatic int evict_victim();
        int i;
        int v;
        v = -1;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && (v < 0 || slot_count[i] < slot_count[v] ||
                (slot_count[i] == slot_count[v] && slot_age[i] > slot_age[v]))) begin
                v = i;
            end
        end
        if (v < 0) return -1;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && i != v && slot_age[i] > slot_age[v]) slot_age[i]--;
        end
        slot_used[v] = 1'b0;
        if (fill_level > 0) fill_level--;
        evict_total++;
        return v;
    endfunction

    function automatic void apply_put(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
        int lim;
        int s;
        int i;
        lim = (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
        put_total++;
        if (lim == 0) return;
        s = find_slot(k);
        if (s >= 0) begin
            slot_data[s] = d;
            promote_slot(s);
            return;
        end
        if (fill_level < lim) begin
            for (i = 0; i < SLOTS; i++) begin
                if (!slot_used[i]) begin
                    s = i;
                    break;
                end
            end
        end
        if (s < 0) s = evict_victim();
        if (s < 0) return;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) slot_age[i]++;
        end
        slot_used[s]  = 1'b1;
        slot_key[s]   = k;
        slot_data[s]  = d;
        slot_count[s] = 16'd1;
        slot_age[s]   = 0;
        fill_level++;
    endfunction

    function automatic void apply_get(input logic [KEY_W-1:0] k);
        int s;
        t_read_result r;
        s = find_slot(k);
        get_total++;
        if (s < 0) begin
            r.hit   = 1'b0;
            r.value = READ_MISS;
        end else begin
            promote_slot(s);
            r.hit   = 1'b1;
            r.value = slot_data[s];
            hit_total++;
        end
        pending_reads = {pending_reads, r};
    endfunction

    function automatic void cache_apply(input logic f, input logic [KEY_W-1:0] k,
                                        input logic [DATA_W-1:0] d);
        if (f == FUNC_PUT) begin
            apply_put(k, d);
        end else begin
            apply_get(k);
        end
    endfunction

    task automatic send_item(input logic f, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] d);
        @(negedge i_clk);
        while (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_func       = f;
        i_key        = k;
        i_data_value = d;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        cache_apply(f, k, d);
    endtask

    task automatic await_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // puts give no result, so allow for one still in flight
    task automatic settle_block();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] cap);
        settle_block();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = cap;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        cap_setting = cap;
    endtask

    task automatic test_basic_lookup();
        feed_idle_pct = 0;
        out_stall_pct = 0;
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0000, 32'h5555_5555);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        send_item(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        send_item(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    endtask

    // capacity drops below occupancy, then lfu with recency tie-break
    task automatic test_lfu_eviction();
        set_capacity(5'd2);
        send_item(FUNC_PUT, 32'h0000_00A0, 32'h0000_0A0A);
        send_item(FUNC_GET, 32'h0000_00A0, 32'h0000_0000);
        send_item(FUNC_PUT, 32'h0000_00B0, 32'h0000_0B0B);
        send_item(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_capacity_zero();
        set_capacity(5'd0);
        send_item(FUNC_PUT, 32'h0000_0C00, 32'h0000_0055);
        send_item(FUNC_GET, 32'h0000_0C00, 32'h0000_0000);
        send_item(FUNC_GET, 32'h0000_00A0, 32'h0000_0000);
    endtask

    task automatic run_traffic(input logic [CFG_W-1:0] cap, input int feed_pct,
                               input int stall_pct, input int count);
        logic [KEY_W-1:0] pool [2*SLOTS+2];
        logic [KEY_W-1:0] k;
        logic             f;
        int               width;
        int               i;
        width = ((cap > SLOTS) ? SLOTS : int'(cap)) * 2 + 2;
        set_capacity(cap);
        feed_idle_pct = feed_pct;
        out_stall_pct = stall_pct;
        for (i = 0; i < width; i++) pool[i] = $urandom;
        repeat (count) begin
            if ($urandom_range(99) < 85) begin
                k = pool[$urandom_range(width - 1)];
            end else begin
                k = $urandom;
            end
            f = ($urandom_range(99) < 45) ? FUNC_PUT : FUNC_GET;
            send_item(f, k, $urandom);
        end
    endtask

    task automatic test_backpressure();
        logic [KEY_W-1:0] keys [4];
        int n;
        set_capacity(5'd8);
        feed_idle_pct = 0;
        out_stall_pct = 0;
        for (n = 0; n < 4; n++) keys[n] = $urandom;
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 40; n++) begin
            send_item((n % 3 == 0) ? FUNC_PUT : FUNC_GET, keys[n % 4], $urandom);
        end
        await_results();
        feed_idle_pct = 37;
        out_stall_pct = 37;
        for (n = 0; n < 40; n++) begin
            send_item($urandom_range(1) ? FUNC_PUT : FUNC_GET, keys[$urandom_range(3)],
                      $urandom);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_reads
        t_read_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_reads.size() == 0) begin
                flag_error("read result with nothing pending");
            end else begin
                want = pending_reads[0];
                pending_reads.delete(0);
                read_total++;
                if (o_hit !== want.hit) begin
                    flag_error($sformatf("hit: expected %0b, got %0b", want.hit, o_hit));
                end
                if (o_read_value !== want.value) begin
                    flag_error($sformatf("read_value: expected %h, got %h",
                                         want.value, o_read_value));
                end
            end
        end
    end

    initial begin
        clear_model();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_lookup();
        test_lfu_eviction();
        test_capacity_zero();
        run_traffic(5'd16, 0, 0, 300);
        run_traffic(5'd31, 61, 0, 300);
        run_traffic(5'd1, 0, 61, 250);
        run_traffic(5'd5, 37, 37, 300);
        run_traffic(5'd0, 0, 0, 150);
        run_traffic(5'd12, 37, 37, 300);
        run_traffic(5'd3, 61, 0, 250);
        test_backpressure();
        settle_block();
        if (pending_reads.size() != 0) begin
            flag_error($sformatf("%0d reads never answered", pending_reads.size()));
        end
        $display("run covered %0d gets (%0d hits, %0d results checked), %0d puts, %0d evictions",
                 get_total, hit_total, read_total, put_total, evict_total);
        $display("capacities 0 to 31, idle and stall mixes, and a long output hold");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d reads pending", pending_reads.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
